// File: hdl/csg_pkg.sv
// Shared types, codes and helpers for the color-stop gradient table.
package csg_pkg;

  localparam int MAX_STOPS_DEF = 32;
  localparam int POS_W         = 17;
  localparam int COLOR_W       = 32;
  localparam int ENTRY_W       = POS_W + COLOR_W;
  localparam int DIV_STEPS     = 10;

  localparam logic [1:0] ACT_INSERT     = 2'd0;
  localparam logic [1:0] ACT_CLEAR      = 2'd1;
  localparam logic [1:0] ACT_READ_STOP  = 2'd2;
  localparam logic [1:0] ACT_READ_ENTRY = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_READ_ONLY = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic CFG_INCLUDE_ALPHA = 1'b0;
  localparam logic CFG_READ_ONLY     = 1'b1;

  localparam logic [16:0] NEAR_LIMIT = 17'd66;

  typedef enum logic [1:0] {RA_K, RA_KM1, RA_J, RA_J1} rsel_t;

  typedef struct packed {
    logic       capture;
    logic       k_clr;
    logic       k_one;
    logic       k_inc;
    logic       k_dec;
    logic       k_cnt;
    logic       k_clamp;
    logic       k_last;
    logic       idx_save;
    logic       j_clr;
    logic       j_ld;
    logic       lo_ld;
    logic       hi_ld;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       wr_shift;
    logic       wr_new;
    rsel_t      rd_sel;
    logic       set_status;
    logic [2:0] status;
    logic       res_stop;
    logic       res_pack;
    logic       res_acc;
    logic       ch_clr;
    logic       mul;
    logic       sum;
    logic       div;
    logic       ch_done;
    logic       out_load;
  } csg_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       read_only;
    logic       pos_bad;
    logic       cnt_zero;
    logic       cnt_one;
    logic       cnt_full;
    logic       idx_first;
    logic       idx_last;
    logic       k_eq_cnt;
    logic       k_eq_idx;
    logic       k_ge_last;
    logic       scan_le;
    logic       near;
    logic       srch_lt;
    logic       div_last;
    logic       ch_last;
    logic       out_free;
  } csg_sts_t;

  // Position times 255, as a shift and a subtract.
  function automatic logic [24:0] times255(input logic [16:0] p);
    return {p, 8'd0} - {8'd0, p};
  endfunction

endpackage

// File: hdl/color_stop_gradient_lut.sv
// Top level of the color-stop gradient table: controller, datapath and stop memory.
// Insert scans the stops and shifts those above the new one up; a colormap entry may
// search the stops and then work the four channels in turn. One word is worked at
// a time; a new word is taken while the last result waits.
// Reset (rst_n low, synchronous) empties the table and clears both config registers.
module color_stop_gradient_lut #(
  parameter int MAX_STOPS = csg_pkg::MAX_STOPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [17:0] in_stop_position,
  input  logic [7:0]         in_stop_red,
  input  logic [7:0]         in_stop_green,
  input  logic [7:0]         in_stop_blue,
  input  logic [7:0]         in_stop_alpha,
  input  logic [7:0]         in_item_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [31:0]        out_color_word,
  output logic [16:0]        out_position_out,
  output logic [5:0]         out_stop_total
);
  import csg_pkg::*;

  // The controller drives one command bundle per cycle; the datapath answers
  // with comparison and count flags that steer the next state.
  csg_cmd_t cmd;
  csg_sts_t sts;

  csg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the sorted stop memory, the stop count, the config
  // registers, the interpolation multipliers and the bit-serial divider, and the
  // output register that lets the next word in while a result is still held.
  csg_dp #(.MAX_STOPS(MAX_STOPS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_stop_position (in_stop_position),
    .in_stop_red      (in_stop_red),
    .in_stop_green    (in_stop_green),
    .in_stop_blue     (in_stop_blue),
    .in_stop_alpha    (in_stop_alpha),
    .in_item_index    (in_item_index),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_color_word   (out_color_word),
    .out_position_out (out_position_out),
    .out_stop_total   (out_stop_total)
  );

endmodule

// File: hdl/csg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csg_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/csg_dp.sv
// Datapath: stop memory, counters, interpolation arithmetic and result registers.
module csg_dp #(
  parameter int MAX_STOPS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_data,
  input  logic [1:0]         in_action,
  input  logic signed [17:0] in_stop_position,
  input  logic [7:0]         in_stop_red,
  input  logic [7:0]         in_stop_green,
  input  logic [7:0]         in_stop_blue,
  input  logic [7:0]         in_stop_alpha,
  input  logic [7:0]         in_item_index,
  input  csg_pkg::csg_cmd_t  cmd,
  output csg_pkg::csg_sts_t  sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [31:0]        out_color_word,
  output logic [16:0]        out_position_out,
  output logic [5:0]         out_stop_total
);
  import csg_pkg::*;

  localparam int CW = $clog2(MAX_STOPS + 1);
  localparam int AW = $clog2(MAX_STOPS);

  logic               incl_alpha_r, read_only_r;
  logic [1:0]         act_r;
  logic signed [17:0] pos_r;
  logic [31:0]        color_r;
  logic [7:0]         item_r;
  logic [CW-1:0]      cnt_r, k_r, idx_r, km1;
  logic [AW-1:0]      j_r, raddr;
  logic [16:0]        lo_pos_r, hi_pos_r;
  logic [31:0]        lo_col_r, hi_col_r, acc_r;
  logic [1:0]         ch_r;
  logic [32:0]        prod0_r;
  logic signed [35:0] prod1_r;
  logic [39:0]        rem_r, dsh_r;
  logic [9:0]         q_r;
  logic [3:0]         dstep_r;
  logic               deg_r, gt_r, tpos_r;
  logic [2:0]         res_status_r;
  logic [31:0]        res_word_r;
  logic [16:0]        res_pos_r;
  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [31:0]        out_word_r;
  logic [16:0]        out_pos_r;
  logic [5:0]         out_total_r;

  logic [ENTRY_W-1:0] rdata, wdata;
  logic [16:0]        rd_pos;
  logic [31:0]        rd_col;
  logic [25:0]        x26, a26, b26;
  logic [24:0]        den;
  logic signed [26:0] xa;
  logic [7:0]         c0, c1, byte_v;
  logic signed [8:0]  dc;
  logic signed [39:0] t;
  logic [8:0]         cnt9;
  logic [CW:0]        k_p1;

  csg_ram #(.W(ENTRY_W), .DEPTH(MAX_STOPS)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_shift | cmd.wr_new),
    .waddr (k_r[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_pos = rdata[ENTRY_W-1:COLOR_W];
  assign rd_col = rdata[COLOR_W-1:0];
  assign wdata  = cmd.wr_new ? {pos_r[16:0], color_r} : rdata;
  assign km1    = k_r - CW'(1);
  assign cnt9   = 9'(cnt_r);
  assign k_p1   = {1'b0, k_r} + (CW+1)'(1);

  always_comb begin
    case (cmd.rd_sel)
      RA_K:    raddr = k_r[AW-1:0];
      RA_KM1:  raddr = km1[AW-1:0];
      RA_J:    raddr = j_r;
      RA_J1:   raddr = j_r + AW'(1);
      default: raddr = k_r[AW-1:0];
    endcase
  end

  // Interpolation operands; the entry index sits at i * 65536 / 255.
  assign x26 = 26'({item_r, 16'd0});
  assign a26 = 26'(times255(lo_pos_r));
  assign b26 = 26'(times255(hi_pos_r));
  assign den = 25'(b26 - a26);
  assign xa  = $signed({1'b0, x26}) - $signed({1'b0, a26});
  assign c0  = lo_col_r[{ch_r, 3'b000} +: 8];
  assign c1  = hi_col_r[{ch_r, 3'b000} +: 8];
  assign dc  = $signed({1'b0, c1}) - $signed({1'b0, c0});
  assign t   = $signed({7'd0, prod0_r}) + 40'(prod1_r);

  always_comb begin
    if (deg_r) begin
      byte_v = gt_r ? c1 : c0;
    end else if (!tpos_r) begin
      byte_v = 8'd0;
    end else if (q_r[9] | q_r[8]) begin
      byte_v = 8'd255;
    end else begin
      byte_v = q_r[7:0];
    end
  end

  always_comb begin
    sts.action    = act_r;
    sts.read_only = read_only_r;
    sts.pos_bad   = pos_r[17] || (pos_r > 18'sd65536);
    sts.cnt_zero  = cnt_r == '0;
    sts.cnt_one   = cnt_r == CW'(1);
    sts.cnt_full  = cnt_r == CW'(MAX_STOPS);
    sts.idx_first = item_r == 8'd0;
    sts.idx_last  = item_r == 8'd255;
    sts.k_eq_cnt  = k_r == cnt_r;
    sts.k_eq_idx  = k_r == idx_r;
    sts.k_ge_last = k_p1 >= {1'b0, cnt_r};
    sts.scan_le   = rd_pos <= pos_r[16:0];
    sts.near      = (rd_pos - pos_r[16:0]) < NEAR_LIMIT;
    sts.srch_lt   = 26'(times255(rd_pos)) < x26;
    sts.div_last  = dstep_r == '0;
    sts.ch_last   = ch_r == 2'd3;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      incl_alpha_r <= 1'b0;
      read_only_r  <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INCLUDE_ALPHA: incl_alpha_r <= cfg_data;
          CFG_READ_ONLY:     read_only_r  <= cfg_data;
          default:           ;
        endcase
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r        <= in_action;
      pos_r        <= in_stop_position;
      color_r      <= {in_stop_alpha, in_stop_red, in_stop_green, in_stop_blue};
      item_r       <= in_item_index;
      res_status_r <= ST_OK;
      res_word_r   <= '0;
      res_pos_r    <= '0;
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_one) begin
      k_r <= CW'(1);
    end else if (cmd.k_inc) begin
      k_r <= k_r + CW'(1);
    end else if (cmd.k_dec) begin
      k_r <= km1;
    end else if (cmd.k_cnt) begin
      k_r <= cnt_r;
    end else if (cmd.k_clamp) begin
      k_r <= (9'(item_r) < cnt9) ? CW'(item_r) : cnt_r - CW'(1);
    end else if (cmd.k_last) begin
      k_r <= cnt_r - CW'(1);
    end
    if (cmd.idx_save) begin
      idx_r <= k_r;
    end
    if (cmd.j_clr) begin
      j_r <= '0;
    end else if (cmd.j_ld) begin
      j_r <= k_r[AW-1:0];
    end
    if (cmd.lo_ld) begin
      lo_pos_r <= rd_pos;
      lo_col_r <= rd_col;
    end
    if (cmd.hi_ld) begin
      hi_pos_r <= rd_pos;
      hi_col_r <= rd_col;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
    if (cmd.res_stop) begin
      res_word_r <= rd_col;
      res_pos_r  <= rd_pos;
    end else if (cmd.res_pack) begin
      res_word_r <= incl_alpha_r ? rd_col : {8'd0, rd_col[23:0]};
    end else if (cmd.res_acc) begin
      res_word_r <= incl_alpha_r ? acc_r : {8'd0, acc_r[23:0]};
    end
    if (cmd.ch_clr) begin
      ch_r <= '0;
    end else if (cmd.ch_done) begin
      acc_r[{ch_r, 3'b000} +: 8] <= byte_v;
      ch_r <= ch_r + 2'd1;
    end
    if (cmd.mul) begin
      prod0_r <= 33'(c0) * 33'(den);
      prod1_r <= 36'(dc) * 36'(xa);
    end
    if (cmd.sum) begin
      deg_r   <= b26 <= a26;
      gt_r    <= x26 > a26;
      tpos_r  <= t > 40'sd0;
      rem_r   <= 40'((t <<< 1) + $signed({15'd0, den}));
      dsh_r   <= 40'({den, 10'd0});
      q_r     <= '0;
      dstep_r <= 4'(DIV_STEPS - 1);
    end else if (cmd.div) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[8:0], 1'b1};
      end else begin
        q_r   <= {q_r[8:0], 1'b0};
      end
      dsh_r   <= dsh_r >> 1;
      dstep_r <= dstep_r - 4'd1;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_word_r   <= res_word_r;
      out_pos_r    <= res_pos_r;
      out_total_r  <= 6'(cnt_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_color_word   = out_word_r;
  assign out_position_out = out_pos_r;
  assign out_stop_total   = out_total_r;

endmodule

// File: hdl/csg_ctrl.sv
// Controller: sequences each word through the steps its action needs, such as scan, shift, search and divide.
module csg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  csg_pkg::csg_sts_t sts,
  output csg_pkg::csg_cmd_t cmd
);
  import csg_pkg::*;

  typedef enum logic [23:0] {
    S_IDLE      = 24'h000001,
    S_DISP      = 24'h000002,
    S_SCAN      = 24'h000004,
    S_SCAN_CMP  = 24'h000008,
    S_INSNEW    = 24'h000010,
    S_SHIFT     = 24'h000020,
    S_SHIFT_WR  = 24'h000040,
    S_WRITE_INC = 24'h000080,
    S_WRITE     = 24'h000100,
    S_RS_RD     = 24'h000200,
    S_RS_OUT    = 24'h000400,
    S_EC_RD     = 24'h000800,
    S_EC_OUT    = 24'h001000,
    S_SRCH      = 24'h002000,
    S_SRCH_CMP  = 24'h004000,
    S_J_RD      = 24'h008000,
    S_J_RD1     = 24'h010000,
    S_J_RD2     = 24'h020000,
    S_MUL       = 24'h040000,
    S_SUM       = 24'h080000,
    S_DIV       = 24'h100000,
    S_CH_DONE   = 24'h200000,
    S_ENT_OUT   = 24'h400000,
    S_FIN       = 24'h800000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RA_K;
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_FIN;
        case (sts.action)
          ACT_INSERT: begin
            if (sts.read_only) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_READ_ONLY;
            end else if (sts.pos_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else begin
              cmd.k_clr = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          ACT_CLEAR: begin
            if (sts.read_only) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_READ_ONLY;
            end else begin
              cmd.cnt_clr = 1'b1;
            end
          end
          ACT_READ_STOP: begin
            if (sts.cnt_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else begin
              cmd.k_clamp = 1'b1;
              state_nxt   = S_RS_RD;
            end
          end
          default: begin
            if (sts.cnt_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else if (sts.cnt_one || sts.idx_first) begin
              cmd.k_clr = 1'b1;
              state_nxt = S_EC_RD;
            end else if (sts.idx_last) begin
              cmd.k_last = 1'b1;
              state_nxt  = S_EC_RD;
            end else begin
              cmd.k_one = 1'b1;
              cmd.j_clr = 1'b1;
              state_nxt = S_SRCH;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (sts.k_eq_cnt) begin
          state_nxt = S_INSNEW;
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.scan_le) begin
          cmd.k_inc = 1'b1;
          state_nxt = S_SCAN;
        end else if (sts.near) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_INSNEW;
        end
      end
      S_INSNEW: begin
        if (sts.cnt_full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
          state_nxt      = S_FIN;
        end else begin
          cmd.idx_save = 1'b1;
          cmd.k_cnt    = 1'b1;
          state_nxt    = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.rd_sel = RA_KM1;
        if (sts.k_eq_idx) begin
          state_nxt = S_WRITE_INC;
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.k_dec    = 1'b1;
        state_nxt    = S_SHIFT;
      end
      S_WRITE_INC: begin
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_FIN;
      end
      S_WRITE: begin
        cmd.wr_new = 1'b1;
        state_nxt  = S_FIN;
      end
      S_RS_RD: begin
        state_nxt = S_RS_OUT;
      end
      S_RS_OUT: begin
        cmd.res_stop = 1'b1;
        state_nxt    = S_FIN;
      end
      S_EC_RD: begin
        state_nxt = S_EC_OUT;
      end
      S_EC_OUT: begin
        cmd.res_pack = 1'b1;
        state_nxt    = S_FIN;
      end
      S_SRCH: begin
        if (sts.k_ge_last) begin
          state_nxt = S_J_RD;
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (sts.srch_lt) begin
          cmd.j_ld  = 1'b1;
          cmd.k_inc = 1'b1;
          state_nxt = S_SRCH;
        end else begin
          state_nxt = S_J_RD;
        end
      end
      S_J_RD: begin
        cmd.rd_sel = RA_J;
        state_nxt  = S_J_RD1;
      end
      S_J_RD1: begin
        cmd.rd_sel = RA_J1;
        cmd.lo_ld  = 1'b1;
        state_nxt  = S_J_RD2;
      end
      S_J_RD2: begin
        cmd.hi_ld  = 1'b1;
        cmd.ch_clr = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_CH_DONE;
        end
      end
      S_CH_DONE: begin
        cmd.ch_done = 1'b1;
        state_nxt   = sts.ch_last ? S_ENT_OUT : S_MUL;
      end
      S_ENT_OUT: begin
        cmd.res_acc = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
